@@ sv/playfair_digraph_cipher_top_assert.svh @@
// assertion macros shared by the playfair digraph cipher modules
`ifndef PLAYFAIR_DIGRAPH_CIPHER_TOP_ASSERT_SVH
`define PLAYFAIR_DIGRAPH_CIPHER_TOP_ASSERT_SVH

// same-cycle implication, disabled during reset
`define PFC_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define PFC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/pfc_pkg.sv @@
// types, constants and helper functions for the playfair digraph cipher
package pfc_pkg;

  localparam logic [4:0] LetterX = 5'd23;
  localparam logic [4:0] LetterJ = 5'd9;
  localparam logic [4:0] LetterI = 5'd8;

  localparam int unsigned CfgIdxW = 3;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_DECRYPT_MODE = 3'd0,
    CFG_SQUARE_ROW0  = 3'd1,
    CFG_SQUARE_ROW1  = 3'd2,
    CFG_SQUARE_ROW2  = 3'd3,
    CFG_SQUARE_ROW3  = 3'd4,
    CFG_SQUARE_ROW4  = 3'd5
  } pfc_cfg_idx_e;

  // row, column, letter code; column 0 in the low bits of a row
  typedef logic [4:0][4:0][4:0] pfc_square_t;

  localparam pfc_square_t SquareReset = {
    25'd27025109, 25'd21613104, 25'd16201099, 25'd10755269, 25'd4294688
  };

  typedef struct packed {
    logic [4:0] letter_in;
    logic       end_of_text;
  } pfc_in_t;

  typedef struct packed {
    logic [4:0] letter_out;
    logic       last_letter;
  } pfc_out_t;

  typedef struct packed {
    logic [4:0] first;
    logic [4:0] second;
    logic       last;
  } pfc_pair_t;

  typedef struct packed {
    logic      en0;
    logic      en1;
    pfc_pair_t pair0;
    pfc_pair_t pair1;
  } pfc_push_t;

  typedef struct packed {
    logic [2:0] row;
    logic [2:0] col;
  } pfc_pos_t;

  // first match in row-major order, row 0 column 0 when absent
  function automatic pfc_pos_t pfc_locate(pfc_square_t sq, logic [4:0] code);
    pfc_pos_t pos;
    pos = '0;
    for (int a = 4; a >= 0; a--) begin
      for (int b = 4; b >= 0; b--) begin
        if (sq[a][b] == code) begin
          pos.row = 3'(a);
          pos.col = 3'(b);
        end
      end
    end
    return pos;
  endfunction

  // one step around the square, left or up when decrypting
  function automatic logic [2:0] pfc_step(logic [2:0] v, logic dec);
    logic [2:0] r;
    if (dec) begin
      r = (v == 3'd0) ? 3'd4 : v - 3'd1;
    end else begin
      r = (v == 3'd4) ? 3'd0 : v + 3'd1;
    end
    return r;
  endfunction

endpackage

@@ sv/playfair_digraph_cipher_top.sv @@
// playfair digraph cipher top level: config registers, front, pair queue, back
// Usage:
//   input channel in_valid_i / in_stall_o / in_data_i carries one letter per beat
//   with end_of_text marking the last letter of a message. The front pairs
//   letters, inserts x filler in encrypt mode and pads an odd last letter.
//   Output channel out_valid_o / out_stall_i / out_data_o carries one letter
//   per beat, last_letter set on the final letter of a message.
//   Config channel cfg_valid_i / cfg_ready_o writes decrypt_mode (index 0) and
//   square rows 0..4 (index 1..5); ready is always high, write only when idle.
// Path: a completed pair passes the pair queue, the locate registers and the output
//   register; its first letter is emitted before its second.
// Throughput: the back emits one letter per cycle while out_stall_i is low;
//   input beats are taken every cycle while the pair queue has room for two.
// Reset: no letter held, queue and pipeline empty, encrypt mode, square a..z
//   without j row by row.
// Stall: a stalled output holds its letter; the pair queue fills and then the
//   input is stalled.
module playfair_digraph_cipher_top import pfc_pkg::*; #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  pfc_in_t            in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output pfc_out_t           out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [24:0]        cfg_data_i
);

  logic        decrypt_mode_q;
  pfc_square_t square_q;
  pfc_push_t   push;
  logic        room, pop, head_valid;
  pfc_pair_t   head;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decrypt_mode_q <= 1'b0;
      square_q       <= SquareReset;
    end else if (cfg_valid_i) begin
      case (pfc_cfg_idx_e'(cfg_index_i))
        CFG_DECRYPT_MODE: decrypt_mode_q <= cfg_data_i[0];
        CFG_SQUARE_ROW0:  square_q[0]    <= cfg_data_i;
        CFG_SQUARE_ROW1:  square_q[1]    <= cfg_data_i;
        CFG_SQUARE_ROW2:  square_q[2]    <= cfg_data_i;
        CFG_SQUARE_ROW3:  square_q[3]    <= cfg_data_i;
        CFG_SQUARE_ROW4:  square_q[4]    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  pfc_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .in_data_i      (in_data_i),
    .decrypt_mode_i (decrypt_mode_q),
    .room_i         (room),
    .push_o         (push)
  );

  pfc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .room_o       (room),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  pfc_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .square_i       (square_q),
    .decrypt_mode_i (decrypt_mode_q),
    .head_valid_i   (head_valid),
    .head_i         (head),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_data_o     (out_data_o)
  );

endmodule

@@ sv/pfc_front.sv @@
// pairing front end: folds j into i, builds digraphs, inserts x filler
module pfc_front import pfc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  pfc_in_t   in_data_i,
  input  logic      decrypt_mode_i,
  input  logic      room_i,
  output pfc_push_t push_o
);

  logic [4:0] held_letter_q, held_letter_d;
  logic       held_valid_q, held_valid_d;
  logic [4:0] letter;
  logic       eot;
  logic       accept;

  assign in_stall_o = !room_i;
  assign accept     = in_valid_i && room_i;
  assign letter     = (in_data_i.letter_in == LetterJ) ? LetterI : in_data_i.letter_in;
  assign eot        = in_data_i.end_of_text;

  always_comb begin
    held_letter_d = held_letter_q;
    held_valid_d  = held_valid_q;
    push_o        = '0;
    if (accept) begin
      if (!held_valid_q) begin
        if (eot) begin
          push_o.en0   = 1'b1;
          push_o.pair0 = '{first: letter, second: LetterX, last: 1'b1};
        end else begin
          held_letter_d = letter;
          held_valid_d  = 1'b1;
        end
      end else if (!decrypt_mode_i && (letter == held_letter_q)) begin
        push_o.en0   = 1'b1;
        push_o.pair0 = '{first: held_letter_q, second: LetterX, last: 1'b0};
        if (eot) begin
          push_o.en1   = 1'b1;
          push_o.pair1 = '{first: letter, second: LetterX, last: 1'b1};
          held_valid_d = 1'b0;
        end else begin
          held_letter_d = letter;
        end
      end else begin
        push_o.en0   = 1'b1;
        push_o.pair0 = '{first: held_letter_q, second: letter, last: eot};
        held_valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_valid_q  <= 1'b0;
      held_letter_q <= '0;
    end else begin
      held_valid_q  <= held_valid_d;
      held_letter_q <= held_letter_d;
    end
  end

endmodule

@@ sv/pfc_queue.sv @@
// short digraph queue between front and back, takes up to two pairs a cycle
module pfc_queue import pfc_pkg::*; #(
  parameter int unsigned Depth = 4
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  pfc_push_t push_i,
  output logic      room_o,
  input  logic      pop_i,
  output logic      head_valid_o,
  output pfc_pair_t head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntRoom = CntW'(Depth - 2);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  pfc_pair_t       entries_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, wr_ptr1;
  logic [CntW-1:0] count_q, count_d;

  function automatic logic [PtrW-1:0] nxt(logic [PtrW-1:0] p);
    return (p == PtrLast) ? '0 : p + PtrW'(1);
  endfunction

  assign wr_ptr1      = nxt(wr_ptr_q);
  assign room_o       = (count_q <= CntRoom);
  assign head_valid_o = (count_q != '0);
  assign head_o       = entries_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    if (push_i.en1) begin
      wr_ptr_d = nxt(wr_ptr1);
    end else if (push_i.en0) begin
      wr_ptr_d = wr_ptr1;
    end
    count_d = count_q + CntW'(push_i.en0) + CntW'(push_i.en1) - CntW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      count_q  <= count_d;
      if (pop_i) begin
        rd_ptr_q <= nxt(rd_ptr_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.en0) begin
      entries_q[wr_ptr_q] <= push_i.pair0;
    end
    if (push_i.en1) begin
      entries_q[wr_ptr1] <= push_i.pair1;
    end
  end

`include "playfair_digraph_cipher_top_assert.svh"

  `PFC_ASSERT(a_pop_nonempty, pop_i, count_q != '0, "pop from empty pair queue")
  `PFC_ASSERT(a_second_push_order, push_i.en1, push_i.en0, "second pair pushed alone")
  `PFC_ASSERT(a_no_overflow, push_i.en0, count_q <= CntRoom, "push into a full pair queue")
  `PFC_ASSERT(a_count_bound, 1'b1, count_q <= CntFull, "pair queue count out of range")

endmodule

@@ sv/pfc_back.sv @@
// back end: locates a pair in the key square and emits its two letters
module pfc_back import pfc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  pfc_square_t square_i,
  input  logic        decrypt_mode_i,
  input  logic        head_valid_i,
  input  pfc_pair_t   head_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output pfc_out_t    out_data_o
);

  logic     s1_valid_q, phase_q, out_valid_q;
  pfc_pos_t pos1_q, pos2_q;
  logic     last_q;
  pfc_out_t out_q;
  logic     out_load, s1_free, s1_load;
  logic [4:0] o1, o2;

  assign out_load = !out_valid_q || !out_stall_i;
  assign s1_free  = !s1_valid_q || (phase_q && out_load);
  assign s1_load  = head_valid_i && s1_free;
  assign pop_o    = s1_load;

  always_comb begin
    if (pos1_q.row == pos2_q.row) begin
      o1 = square_i[pos1_q.row][pfc_step(pos1_q.col, decrypt_mode_i)];
      o2 = square_i[pos2_q.row][pfc_step(pos2_q.col, decrypt_mode_i)];
    end else if (pos1_q.col == pos2_q.col) begin
      o1 = square_i[pfc_step(pos1_q.row, decrypt_mode_i)][pos1_q.col];
      o2 = square_i[pfc_step(pos2_q.row, decrypt_mode_i)][pos2_q.col];
    end else begin
      o1 = square_i[pos1_q.row][pos2_q.col];
      o2 = square_i[pos2_q.row][pos1_q.col];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      phase_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= s1_valid_q;
        if (s1_valid_q) begin
          phase_q <= !phase_q;
        end
      end
      if (s1_load) begin
        s1_valid_q <= 1'b1;
      end else if (phase_q && out_load) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      pos1_q <= pfc_locate(square_i, head_i.first);
      pos2_q <= pfc_locate(square_i, head_i.second);
      last_q <= head_i.last;
    end
    if (out_load && s1_valid_q) begin
      if (phase_q) begin
        out_q <= '{letter_out: o2, last_letter: last_q};
      end else begin
        out_q <= '{letter_out: o1, last_letter: 1'b0};
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`include "playfair_digraph_cipher_top_assert.svh"

  `PFC_ASSERT(a_phase_has_pair, phase_q, s1_valid_q, "second letter pending without a pair")
  `PFC_ASSERT(a_load_from_queue, s1_load, head_valid_i, "pair loaded from empty queue")
  `PFC_ASSERT(a_pos_range, s1_valid_q, (pos1_q.row <= 3'd4) && (pos1_q.col <= 3'd4) &&
              (pos2_q.row <= 3'd4) && (pos2_q.col <= 3'd4), "square position out of range")
  `PFC_ASSERT_NEXT(a_first_then_second, out_load && s1_valid_q && !phase_q,
                   s1_valid_q && phase_q, "first letter emitted without its partner")

endmodule

@@ tb/testbench.sv @@
// self-checking testbench for the playfair digraph cipher top level
`timescale 1ns / 100ps

module testbench;
  import pfc_pkg::*;

  typedef logic [4:0] letter_t;
  typedef logic [4:0][24:0] key_rows_t;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned RandomPhases = 8;
  localparam int unsigned PhaseLetters = 14;

  logic clk_i;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  pfc_in_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  pfc_out_t out_data_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [24:0] cfg_data_i = '0;

  playfair_digraph_cipher_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  // cipher model state
  logic decrypt_q;
  key_rows_t square_q;
  letter_t held_q;
  logic held_valid_q;

  pfc_in_t plaintext_q[$];
  pfc_out_t cipher_due_q[$];

  int unsigned letters_sent;
  int unsigned letters_checked;
  int unsigned reg_writes;
  int unsigned error_cnt;
  int unsigned cycle_cnt;
  int unsigned send_gap;
  int unsigned stall_left;
  logic calm;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic letter_t square_at(int r, int c);
    return square_q[r % 5][5 * (c % 5) +: 5];
  endfunction

  function automatic void find_letter(letter_t code, output int r, output int c);
    logic found;
    found = 1'b0;
    r = 0;
    c = 0;
    for (int a = 0; a < 5; a++) begin
      for (int b = 0; b < 5; b++) begin
        if (!found && square_at(a, b) == code) begin
          found = 1'b1;
          r = a;
          c = b;
        end
      end
    end
  endfunction

  function automatic void queue_pair(letter_t p, letter_t q, logic last);
    int r1, c1, r2, c2, stp;
    letter_t o1, o2;
    pfc_out_t res;
    find_letter(p, r1, c1);
    find_letter(q, r2, c2);
    stp = decrypt_q ? 4 : 1;
    if (r1 == r2) begin
      o1 = square_at(r1, c1 + stp);
      o2 = square_at(r2, c2 + stp);
    end else if (c1 == c2) begin
      o1 = square_at(r1 + stp, c1);
      o2 = square_at(r2 + stp, c2);
    end else begin
      o1 = square_at(r1, c2);
      o2 = square_at(r2, c1);
    end
    res.letter_out = o1;
    res.last_letter = 1'b0;
    cipher_due_q.push_back(res);
    res.letter_out = o2;
    res.last_letter = last;
    cipher_due_q.push_back(res);
  endfunction

  function automatic void encipher_beat(pfc_in_t beat);
    letter_t l;
    l = beat.letter_in;
    if (l == LetterJ) l = LetterI;
    if (!held_valid_q) begin
      if (beat.end_of_text) begin
        queue_pair(l, LetterX, 1'b1);
      end else begin
        held_q = l;
        held_valid_q = 1'b1;
      end
    end else if (!decrypt_q && l == held_q) begin
      queue_pair(held_q, LetterX, 1'b0);
      if (beat.end_of_text) begin
        queue_pair(l, LetterX, 1'b1);
        held_valid_q = 1'b0;
        held_q = '0;
      end else begin
        held_q = l;
      end
    end else begin
      queue_pair(held_q, l, beat.end_of_text);
      held_valid_q = 1'b0;
      held_q = '0;
    end
  endfunction

  function automatic void add_letter(int code, logic eot);
    pfc_in_t beat;
    beat.letter_in = 5'(code);
    beat.end_of_text = eot;
    plaintext_q.push_back(beat);
  endfunction

  function automatic letter_t pick_letter();
    if ($urandom_range(0, 11) == 0) return 5'($urandom_range(26, 31));
    return 5'($urandom_range(0, 25));
  endfunction

  function automatic void add_messages(int unsigned count);
    int unsigned added;
    int unsigned len;
    letter_t l;
    added = 0;
    l = pick_letter();
    while (added < count) begin
      len = $urandom_range(1, 9);
      for (int unsigned k = 0; k < len; k++) begin
        if ($urandom_range(0, 3) != 0) l = pick_letter();
        add_letter(l, k == len - 1);
      end
      added += len;
    end
  endfunction

  function automatic key_rows_t shuffled_square();
    letter_t pool[25];
    letter_t tmp;
    key_rows_t rows;
    int n, omit, k;
    omit = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 25) : int'(LetterJ);
    n = 0;
    for (int v = 0; v < 26; v++) begin
      if (v != omit) begin
        pool[n] = 5'(v);
        n++;
      end
    end
    for (int i = 24; i > 0; i--) begin
      k = $urandom_range(0, i);
      tmp = pool[i];
      pool[i] = pool[k];
      pool[k] = tmp;
    end
    for (int i = 0; i < 25; i++) rows[i / 5][5 * (i % 5) +: 5] = pool[i];
    return rows;
  endfunction

  task automatic write_reg(pfc_cfg_idx_e idx, logic [24:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    reg_writes++;
    if (idx == CFG_DECRYPT_MODE) begin
      decrypt_q = val[0];
    end else begin
      square_q[int'(idx) - int'(CFG_SQUARE_ROW0)] = val;
    end
  endtask

  task automatic load_key(logic dec, key_rows_t rows);
    write_reg(CFG_DECRYPT_MODE, {24'd0, dec});
    write_reg(CFG_SQUARE_ROW0, rows[0]);
    write_reg(CFG_SQUARE_ROW1, rows[1]);
    write_reg(CFG_SQUARE_ROW2, rows[2]);
    write_reg(CFG_SQUARE_ROW3, rows[3]);
    write_reg(CFG_SQUARE_ROW4, rows[4]);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain();
    while (plaintext_q.size() != 0 || in_valid_i || cipher_due_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // letter driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        encipher_beat(in_data_i);
        letters_sent++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (plaintext_q.size() != 0 && !calm && $urandom_range(0, 5) == 0) begin
          send_gap = $urandom_range(0, 3);
          in_valid_i <= 1'b0;
        end else if (plaintext_q.size() != 0) begin
          in_valid_i <= 1'b1;
          in_data_i <= plaintext_q.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // cipher letter monitor
  always @(posedge clk_i) begin
    pfc_out_t due;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (cipher_due_q.size() == 0) begin
        error_cnt++;
        $display("%0t: unexpected cipher letter: expected none, actual letter %0d last %0b",
                 $time, out_data_o.letter_out, out_data_o.last_letter);
      end else begin
        due = cipher_due_q.pop_front();
        letters_checked++;
        if (out_data_o.letter_out !== due.letter_out) begin
          error_cnt++;
          $display("%0t: letter_out mismatch: expected %0d, actual %0d",
                   $time, due.letter_out, out_data_o.letter_out);
        end
        if (out_data_o.last_letter !== due.last_letter) begin
          error_cnt++;
          $display("%0t: last_letter mismatch: expected %0b, actual %0b",
                   $time, due.last_letter, out_data_o.last_letter);
        end
      end
    end
    if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if (rst_ni && !calm && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 3);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("%0t: timeout with %0d cipher letters outstanding", $time, cipher_due_q.size());
      $display("playfair_digraph_cipher_top regression: fail");
      $finish;
    end
  end

  initial begin
    key_rows_t rows;
    logic dec;
    decrypt_q = 1'b0;
    square_q = key_rows_t'(SquareReset);
    held_q = '0;
    held_valid_q = 1'b0;
    letters_sent = 0;
    letters_checked = 0;
    reg_writes = 0;
    error_cnt = 0;
    cycle_cnt = 0;
    send_gap = 0;
    stall_left = 0;
    calm = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // encrypt with the reset square
    load_key(1'b0, key_rows_t'(SquareReset));
    add_letter(0, 1'b0); add_letter(0, 1'b0); add_letter(25, 1'b0);
    add_letter(9, 1'b0); add_letter(8, 1'b0); add_letter(9, 1'b1);
    add_letter(23, 1'b0); add_letter(23, 1'b0); add_letter(23, 1'b1);
    add_letter(31, 1'b0); add_letter(26, 1'b0);
    add_letter(4, 1'b0); add_letter(15, 1'b0);
    add_letter(1, 1'b0); add_letter(2, 1'b1);
    add_letter(12, 1'b1);
    add_letter(3, 1'b0); add_letter(17, 1'b1);
    drain();

    // decrypt: no filler, odd tail still padded
    load_key(1'b1, key_rows_t'(SquareReset));
    add_letter(0, 1'b0); add_letter(0, 1'b0);
    add_letter(4, 1'b0); add_letter(15, 1'b0);
    add_letter(3, 1'b0); add_letter(17, 1'b0);
    add_letter(7, 1'b1);
    drain();

    for (int unsigned ph = 0; ph < RandomPhases; ph++) begin
      dec = 1'($urandom_range(0, 1));
      case (ph)
        0: begin
          rows = '0;
          dec = 1'b0;
        end
        1: begin
          rows = '1;
          dec = 1'b1;
        end
        default: begin
          if ($urandom_range(0, 4) == 0) begin
            for (int r = 0; r < 5; r++) rows[r] = 25'($urandom);
          end else begin
            rows = shuffled_square();
          end
        end
      endcase
      calm = (ph == RandomPhases - 1);
      load_key(dec, rows);
      add_messages(PhaseLetters);
      drain();
    end

    $display("sent %0d letters over %0d register writes in both modes", letters_sent,
             reg_writes);
    $display("checked %0d cipher letters with %0d errors", letters_checked, error_cnt);
    if (error_cnt == 0) begin
      $display("playfair_digraph_cipher_top regression: pass");
    end else begin
      $display("playfair_digraph_cipher_top regression: fail");
    end
    $finish;
  end

endmodule
